[rtl/tcce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CPOS_W = 11;
  localparam int CELL_W = 16;
  localparam int STEP_W = 4;

  localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_SPACE       = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE     = 8'd10;
  localparam logic [BYTE_W-1:0] BLANK_ATTR_RESET = 8'd15;

  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_PUT  = 3'd1,
    CUR_BACK = 3'd2,
    CUR_MOVE = 3'd3,
    CUR_HOME = 3'd4
  } cur_op_t;

  typedef enum logic [1:0] {
    WALK_HOLD = 2'd0,
    WALK_ZERO = 2'd1,
    WALK_INC  = 2'd2
  } walk_op_t;

  typedef enum logic [2:0] {
    MEM_NONE       = 3'd0,
    MEM_PUT        = 3'd1,
    MEM_BACK       = 3'd2,
    MEM_FILL_RST   = 3'd3,
    MEM_FILL       = 3'd4,
    MEM_COPY       = 3'd5,
    MEM_READ_AHEAD = 3'd6,
    MEM_READ_TGT   = 3'd7
  } mem_op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_ACCEPT    = 3'd1,
    COND_WRAP_LAST = 3'd2,
    COND_WALK_COPY = 3'd3,
    COND_WALK_LAST = 3'd4,
    COND_OUT_FREE  = 3'd5
  } cond_t;

  typedef struct packed {
    logic              in_ready;
    logic              out_load;
    cur_op_t           cur_op;
    walk_op_t          walk_op;
    mem_op_t           mem_op;
    cond_t             cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] nxt;
  } ctrl_t;

  typedef struct packed {
    logic              accept;
    logic [KIND_W-1:0] kind;
    logic              wrap_last;
    logic              walk_copy_end;
    logic              walk_last;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/tcce_intf.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tcce_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::KIND_W-1:0]      kind;
  logic [tcce_pkg::BYTE_W-1:0]      char_code;
  logic [tcce_pkg::BYTE_W-1:0]      attribute;
  logic [tcce_pkg::ROW_W-1:0]       row;
  logic [tcce_pkg::COL_W-1:0]       col;

  modport source (output valid, kind, char_code, attribute, row, col, input ready);
  modport sink   (input valid, kind, char_code, attribute, row, col, output ready);
endinterface

interface tcce_res_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::ROW_W-1:0]       cursor_row_out;
  logic [tcce_pkg::COL_W-1:0]       cursor_col_out;
  logic [tcce_pkg::CPOS_W-1:0]      cursor_position;
  logic [tcce_pkg::BYTE_W-1:0]      cell_char;
  logic [tcce_pkg::BYTE_W-1:0]      cell_attr;

  modport source (output valid, cursor_row_out, cursor_col_out, cursor_position,
                  cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_row_out, cursor_col_out, cursor_position,
                  cell_char, cell_attr, output ready);
endinterface

interface tcce_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::BYTE_W-1:0]      blank_attr;

  modport source (output valid, blank_attr, input ready);
  modport sink   (input valid, blank_attr, output ready);
endinterface

`default_nettype wire

[rtl/tcce_useq.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcce_useq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tcce_pkg::stat_t stat,
  output tcce_pkg::ctrl_t      ctrl
);

  localparam logic [tcce_pkg::STEP_W-1:0] S_INIT   = 4'd0;
  localparam logic [tcce_pkg::STEP_W-1:0] S_IDLE   = 4'd1;
  localparam logic [tcce_pkg::STEP_W-1:0] S_PUT    = 4'd2;
  localparam logic [tcce_pkg::STEP_W-1:0] S_SCR0   = 4'd3;
  localparam logic [tcce_pkg::STEP_W-1:0] S_SCR1   = 4'd4;
  localparam logic [tcce_pkg::STEP_W-1:0] S_SCR2   = 4'd5;
  localparam logic [tcce_pkg::STEP_W-1:0] S_BACK   = 4'd6;
  localparam logic [tcce_pkg::STEP_W-1:0] S_MOVE   = 4'd7;
  localparam logic [tcce_pkg::STEP_W-1:0] S_CLEAR  = 4'd8;
  localparam logic [tcce_pkg::STEP_W-1:0] S_READ   = 4'd9;
  localparam logic [tcce_pkg::STEP_W-1:0] S_FINISH = 4'd10;

  logic [tcce_pkg::STEP_W-1:0] upc;
  logic [tcce_pkg::STEP_W-1:0] upc_next;
  logic                        taken;

  // Microprogram: jmp if cond holds (by kind on accept), else nxt.
  function automatic tcce_pkg::ctrl_t rom_word(input logic [tcce_pkg::STEP_W-1:0] s);
    tcce_pkg::ctrl_t w;
    w.in_ready = 1'b0;
    w.out_load = 1'b0;
    w.cur_op   = tcce_pkg::CUR_HOLD;
    w.walk_op  = tcce_pkg::WALK_HOLD;
    w.mem_op   = tcce_pkg::MEM_NONE;
    w.cond     = tcce_pkg::COND_ALWAYS;
    w.jmp      = S_IDLE;
    w.nxt      = S_IDLE;
    unique case (s)
      S_INIT: begin
        w.mem_op  = tcce_pkg::MEM_FILL_RST;
        w.walk_op = tcce_pkg::WALK_INC;
        w.cond    = tcce_pkg::COND_WALK_LAST;
        w.jmp     = S_IDLE;
        w.nxt     = S_INIT;
      end
      S_IDLE: begin
        w.in_ready = 1'b1;
        w.walk_op  = tcce_pkg::WALK_ZERO;
        w.cond     = tcce_pkg::COND_ACCEPT;
        w.nxt      = S_IDLE;
      end
      S_PUT: begin
        w.cur_op = tcce_pkg::CUR_PUT;
        w.mem_op = tcce_pkg::MEM_PUT;
        w.cond   = tcce_pkg::COND_WRAP_LAST;
        w.jmp    = S_SCR0;
        w.nxt    = S_FINISH;
      end
      S_SCR0: begin
        w.mem_op = tcce_pkg::MEM_READ_AHEAD;
        w.jmp    = S_SCR1;
      end
      S_SCR1: begin
        w.mem_op  = tcce_pkg::MEM_COPY;
        w.walk_op = tcce_pkg::WALK_INC;
        w.cond    = tcce_pkg::COND_WALK_COPY;
        w.jmp     = S_SCR2;
        w.nxt     = S_SCR1;
      end
      S_SCR2: begin
        w.mem_op  = tcce_pkg::MEM_FILL;
        w.walk_op = tcce_pkg::WALK_INC;
        w.cond    = tcce_pkg::COND_WALK_LAST;
        w.jmp     = S_FINISH;
        w.nxt     = S_SCR2;
      end
      S_BACK: begin
        w.cur_op = tcce_pkg::CUR_BACK;
        w.mem_op = tcce_pkg::MEM_BACK;
        w.jmp    = S_FINISH;
      end
      S_MOVE: begin
        w.cur_op = tcce_pkg::CUR_MOVE;
        w.jmp    = S_FINISH;
      end
      S_CLEAR: begin
        w.cur_op  = tcce_pkg::CUR_HOME;
        w.mem_op  = tcce_pkg::MEM_FILL;
        w.walk_op = tcce_pkg::WALK_INC;
        w.cond    = tcce_pkg::COND_WALK_LAST;
        w.jmp     = S_FINISH;
        w.nxt     = S_CLEAR;
      end
      S_READ: begin
        w.mem_op = tcce_pkg::MEM_READ_TGT;
        w.jmp    = S_FINISH;
      end
      S_FINISH: begin
        w.out_load = 1'b1;
        w.cond     = tcce_pkg::COND_OUT_FREE;
        w.jmp      = S_IDLE;
        w.nxt      = S_FINISH;
      end
      default: begin
        w.jmp = S_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [tcce_pkg::STEP_W-1:0] dispatch(
    input logic [tcce_pkg::KIND_W-1:0] k
  );
    logic [tcce_pkg::STEP_W-1:0] d;
    unique case (k)
      tcce_pkg::KIND_PUT:   d = S_PUT;
      tcce_pkg::KIND_BACK:  d = S_BACK;
      tcce_pkg::KIND_MOVE:  d = S_MOVE;
      tcce_pkg::KIND_CLEAR: d = S_CLEAR;
      tcce_pkg::KIND_READ:  d = S_READ;
      default:              d = S_FINISH;
    endcase
    return d;
  endfunction

  always_comb begin
    ctrl = rom_word(upc);
  end

  always_comb begin
    unique case (ctrl.cond)
      tcce_pkg::COND_ALWAYS:    taken = 1'b1;
      tcce_pkg::COND_ACCEPT:    taken = stat.accept;
      tcce_pkg::COND_WRAP_LAST: taken = stat.wrap_last;
      tcce_pkg::COND_WALK_COPY: taken = stat.walk_copy_end;
      tcce_pkg::COND_WALK_LAST: taken = stat.walk_last;
      tcce_pkg::COND_OUT_FREE:  taken = stat.out_free;
      default:                  taken = 1'b0;
    endcase
    if (!taken) begin
      upc_next = ctrl.nxt;
    end else if (ctrl.cond == tcce_pkg::COND_ACCEPT) begin
      upc_next = dispatch(stat.kind);
    end else begin
      upc_next = ctrl.jmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_INIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

[rtl/tcce_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcce_datapath #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tcce_pkg::ctrl_t ctrl,
  output tcce_pkg::stat_t      stat,
  tcce_cmd_if.sink             cmd,
  tcce_res_if.source           res,
  tcce_cfg_if.sink             cfg
);

  localparam int NCELLS      = SCREEN_ROWS * SCREEN_COLS;
  localparam int COPY_CELLS  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(NCELLS);
  localparam int RA_W        = ADDR_W + 1;

  localparam logic [tcce_pkg::ROW_W-1:0] LAST_ROW  = tcce_pkg::ROW_W'(SCREEN_ROWS - 1);
  localparam logic [tcce_pkg::COL_W-1:0] LAST_COL  = tcce_pkg::COL_W'(SCREEN_COLS - 1);
  localparam logic [ADDR_W-1:0]          LAST_CELL = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0]          COPY_END  = ADDR_W'(COPY_CELLS - 1);
  localparam logic [ADDR_W-1:0]          COLS_A    = ADDR_W'(SCREEN_COLS);
  localparam logic [RA_W-1:0]            COLS_R    = RA_W'(SCREEN_COLS);
  localparam logic [RA_W-1:0]            NCELLS_R  = RA_W'(NCELLS);

  logic [tcce_pkg::BYTE_W-1:0] blank_attr;

  logic [tcce_pkg::KIND_W-1:0] kind_q;
  logic [tcce_pkg::BYTE_W-1:0] char_q;
  logic [tcce_pkg::BYTE_W-1:0] attr_q;
  logic [tcce_pkg::ROW_W-1:0]  row_q;
  logic [tcce_pkg::COL_W-1:0]  col_q;

  logic [tcce_pkg::ROW_W-1:0]  cur_row;
  logic [tcce_pkg::COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0]           walk;

  logic [tcce_pkg::CELL_W-1:0] cell_mem [NCELLS];
  logic [tcce_pkg::CELL_W-1:0] rd_data;

  logic                        accept;
  logic                        out_free;
  logic [tcce_pkg::ROW_W-1:0]  trow;
  logic [tcce_pkg::COL_W-1:0]  tcol;
  logic [ADDR_W-1:0]           pos;
  logic [ADDR_W-1:0]           tpos;
  logic                        wrap;
  logic                        row_last;
  logic [tcce_pkg::CELL_W-1:0] blank_cell;

  logic                        we;
  logic [ADDR_W-1:0]           wa;
  logic [tcce_pkg::CELL_W-1:0] wd;
  logic                        re;
  logic [RA_W-1:0]             ra;
  logic [RA_W-1:0]             ahead;
  logic [RA_W-1:0]             ahead1;

  assign cmd.ready = ctrl.in_ready;
  assign cfg.ready = 1'b1;
  assign accept    = cmd.valid && ctrl.in_ready;
  assign out_free  = !res.valid || res.ready;

  assign trow = (row_q > LAST_ROW) ? LAST_ROW : row_q;
  assign tcol = (col_q > LAST_COL) ? LAST_COL : col_q;
  assign pos  = ADDR_W'(cur_row) * COLS_A + ADDR_W'(cur_col);
  assign tpos = ADDR_W'(trow) * COLS_A + ADDR_W'(tcol);

  // a put leaves the row on newline or at the last column
  assign wrap       = (char_q == tcce_pkg::CHAR_NEWLINE) || (cur_col == LAST_COL);
  assign row_last   = (cur_row == LAST_ROW);
  assign blank_cell = {blank_attr, tcce_pkg::CHAR_SPACE};

  // during scroll, the cell one row below the walk pointer is read ahead to feed the copy
  assign ahead  = RA_W'(walk) + COLS_R;
  assign ahead1 = ahead + RA_W'(1);

  always_comb begin
    stat.accept        = accept;
    stat.kind          = cmd.kind;
    stat.wrap_last     = wrap && row_last;
    stat.walk_copy_end = (walk == COPY_END);
    stat.walk_last     = (walk == LAST_CELL);
    stat.out_free      = out_free;
  end

  always_comb begin
    we = 1'b0;
    wa = walk;
    wd = blank_cell;
    re = 1'b0;
    ra = ahead;
    unique case (ctrl.mem_op)
      tcce_pkg::MEM_NONE: begin
      end
      tcce_pkg::MEM_PUT: begin
        we = (char_q != tcce_pkg::CHAR_NEWLINE);
        wa = pos;
        wd = {attr_q, char_q};
      end
      tcce_pkg::MEM_BACK: begin
        we = (pos != '0);
        wa = pos - ADDR_W'(1);
      end
      tcce_pkg::MEM_FILL_RST: begin
        we = 1'b1;
        wd = {tcce_pkg::BLANK_ATTR_RESET, tcce_pkg::CHAR_SPACE};
      end
      tcce_pkg::MEM_FILL: begin
        we = 1'b1;
      end
      tcce_pkg::MEM_COPY: begin
        we = 1'b1;
        wd = rd_data;
        re = (ahead1 < NCELLS_R);
        ra = ahead1;
      end
      tcce_pkg::MEM_READ_AHEAD: begin
        re = 1'b1;
      end
      tcce_pkg::MEM_READ_TGT: begin
        re = 1'b1;
        ra = RA_W'(tpos);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= cell_mem[ra[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attr <= tcce_pkg::BLANK_ATTR_RESET;
    end else if (cfg.valid) begin
      blank_attr <= cfg.blank_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= cmd.kind;
      char_q <= cmd.char_code;
      attr_q <= cmd.attribute;
      row_q  <= cmd.row;
      col_q  <= cmd.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else begin
      case (ctrl.walk_op)
        tcce_pkg::WALK_ZERO: walk <= '0;
        tcce_pkg::WALK_INC:  walk <= walk + ADDR_W'(1);
        default:             walk <= walk;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else begin
      case (ctrl.cur_op)
        tcce_pkg::CUR_PUT: begin
          cur_col <= wrap ? '0 : cur_col + tcce_pkg::COL_W'(1);
          // on the last row the scroll keeps the cursor on that row
          if (wrap && !row_last) begin
            cur_row <= cur_row + tcce_pkg::ROW_W'(1);
          end
        end
        tcce_pkg::CUR_BACK: begin
          if (cur_col != '0) begin
            cur_col <= cur_col - tcce_pkg::COL_W'(1);
          end else if (cur_row != '0) begin
            cur_row <= cur_row - tcce_pkg::ROW_W'(1);
            cur_col <= LAST_COL;
          end
        end
        tcce_pkg::CUR_MOVE: begin
          cur_row <= trow;
          cur_col <= tcol;
        end
        tcce_pkg::CUR_HOME: begin
          cur_row <= '0;
          cur_col <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctrl.out_load && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && out_free) begin
      res.cursor_row_out  <= cur_row;
      res.cursor_col_out  <= cur_col;
      res.cursor_position <= tcce_pkg::CPOS_W'(pos);
      if (kind_q == tcce_pkg::KIND_READ) begin
        res.cell_char <= rd_data[tcce_pkg::BYTE_W-1:0];
        res.cell_attr <= rd_data[tcce_pkg::CELL_W-1:tcce_pkg::BYTE_W];
      end else begin
        res.cell_char <= '0;
        res.cell_attr <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/text_console_cursor_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Text console of SCREEN_ROWS x SCREEN_COLS character/attribute cells with a
// cursor, driven by a small microprogram over one single-port-write cell RAM.
// Every command returns one result. Put, backspace, move and read each pass
// through accept, one command step and the output load, and unused kinds go
// from accept straight to the output load; res.valid is registered there.
// Clear walks the RAM one cell a cycle. A put that runs off the last row
// scrolls: it copies one cell a cycle and then blanks the bottom row. A result
// held by back-pressure stalls the output load step until res frees up.
// After reset the block first blanks the RAM and takes no command until that
// is done; blank_attr writes are taken anytime but should be made with the
// block idle. A new command is accepted while the previous result still waits
// on res.

module text_console_cursor_engine #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tcce_cmd_if.sink   cmd,
  tcce_res_if.source res,
  tcce_cfg_if.sink   cfg
);

  tcce_pkg::ctrl_t ctrl;
  tcce_pkg::stat_t stat;

  tcce_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  tcce_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat),
    .cmd  (cmd),
    .res  (res),
    .cfg  (cfg)
  );

endmodule

`default_nettype wire
